>>> sv/klp_pkg.sv
// shared types, constants and helpers of the key=value line parser
package klp_pkg;

  localparam int unsigned MAX_TEXT_BYTES = 131072;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OFFSET_W   = 17;
  localparam int unsigned LENGTH_W   = 18;
  localparam int unsigned LINE_NUM_W = 18;
  localparam int unsigned ERR_W      = 3;

  // byte position reaches the limit itself, stored offsets stay below it
  localparam int unsigned POS_W  = $clog2(MAX_TEXT_BYTES + 1);
  localparam int unsigned OFF_W  = $clog2(MAX_TEXT_BYTES);
  localparam int unsigned LINE_W = $clog2(MAX_TEXT_BYTES + 2);

  localparam int unsigned WIDE_W = ((POS_W > LINE_W) ? POS_W : LINE_W) + 1;
  localparam int unsigned CALC_W = (WIDE_W > LENGTH_W) ? WIDE_W : LENGTH_W;

  localparam logic [BYTE_W-1:0] CH_NEWLINE    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_EQUALS     = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;

  typedef enum logic [ERR_W-1:0] {
    ERR_NO_DELIM    = 3'd0,
    ERR_KEY_GARBAGE = 3'd1,
    ERR_EXPECT_EQ   = 3'd2,
    ERR_NO_VALUE    = 3'd3,
    ERR_TOO_LARGE   = 3'd4
  } err_code_t;

  typedef enum logic {
    REC_PAIR  = 1'b0,
    REC_ERROR = 1'b1
  } rec_kind_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic restart;
    logic is_key;
    logic is_newline;
    logic is_space;
    logic is_equals;
  } tok_t;

  typedef struct packed {
    rec_kind_t               kind;
    logic [OFFSET_W-1:0]     key_offset;
    logic [LENGTH_W-1:0]     key_length;
    logic [OFFSET_W-1:0]     value_offset;
    logic [LENGTH_W-1:0]     value_length;
    logic [LINE_NUM_W-1:0]   line_number;
    err_code_t               error_code;
  } rec_t;

  function automatic logic is_key_char(input logic [BYTE_W-1:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           ((b >= 8'h30) && (b <= 8'h39)) || (b == CH_UNDERSCORE);
  endfunction

endpackage

>>> sv/klp_front.sv
// front end: takes text bytes, classifies them and queues the tokens
module klp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [klp_pkg::BYTE_W-1:0]  text_byte,
  input  logic                        restart,
  output logic                        full,
  output logic                        tok_valid,
  output klp_pkg::tok_t               tok,
  input  logic                        tok_pop
);

  klp_pkg::tok_t q_r [2];
  klp_pkg::tok_t tok_new;
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push_ok;
  logic          pop_ok;

  assign full      = (cnt_r == 2'd2);
  assign tok_valid = (cnt_r != 2'd0);
  assign tok       = q_r[rp_r];
  assign push_ok   = push && !full;
  assign pop_ok    = tok_pop && tok_valid;

  always_comb begin
    tok_new.restart    = restart;
    tok_new.is_key     = klp_pkg::is_key_char(text_byte);
    tok_new.is_newline = (text_byte == klp_pkg::CH_NEWLINE);
    tok_new.is_space   = (text_byte == klp_pkg::CH_SPACE);
    tok_new.is_equals  = (text_byte == klp_pkg::CH_EQUALS);
    wp_nxt  = push_ok ? ~wp_r : wp_r;
    rp_nxt  = pop_ok ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= tok_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> sv/klp_back.sv
// back end: line parser state machine, position and line counters, result queue
module klp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tok_valid,
  input  klp_pkg::tok_t tok,
  output logic          tok_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output klp_pkg::rec_t rec
);

  typedef enum logic [5:0] {
    PH_KEY_START = 6'b000001,
    PH_KEY_CHAR  = 6'b000010,
    PH_DELIM     = 6'b000100,
    PH_VAL_START = 6'b001000,
    PH_VAL_CHAR  = 6'b010000,
    PH_HALT      = 6'b100000
  } phase_t;

  phase_t                          ph_r, ph_nxt, ph_cur;
  logic [klp_pkg::POS_W-1:0]       pos_r, pos_nxt, pos_cur;
  logic [klp_pkg::LINE_W-1:0]      line_r, line_nxt, line_cur;
  logic [klp_pkg::OFF_W-1:0]       kb_r, kb_nxt, kb_cur;
  logic [klp_pkg::OFF_W-1:0]       kl_r, kl_nxt, kl_cur;
  logic [klp_pkg::OFF_W-1:0]       vb_r, vb_nxt, vb_cur;
  logic [klp_pkg::OFF_W-1:0]       pos_off;
  logic [klp_pkg::CALC_W-1:0]      key_off_w, key_len_w, val_off_w, val_len_w, line_w;

  klp_pkg::rec_t                   rec_new;
  logic                            emit;
  logic                            advance;
  logic                            step;

  klp_pkg::rec_t                   oq_r [2];
  logic                            owp_r, owp_nxt;
  logic                            orp_r, orp_nxt;
  logic [1:0]                      ocnt_r, ocnt_nxt;
  logic                            opush;
  logic                            opop;

  // restart clears the parser before the byte is handled
  always_comb begin
    if (tok.restart) begin
      ph_cur   = PH_KEY_START;
      pos_cur  = '0;
      line_cur = klp_pkg::LINE_W'(1);
      kb_cur   = '0;
      kl_cur   = '0;
      vb_cur   = '0;
    end else begin
      ph_cur   = ph_r;
      pos_cur  = pos_r;
      line_cur = line_r;
      kb_cur   = kb_r;
      kl_cur   = kl_r;
      vb_cur   = vb_r;
    end
  end

  assign pos_off   = pos_cur[klp_pkg::OFF_W-1:0];
  assign key_off_w = klp_pkg::CALC_W'(kb_cur);
  assign key_len_w = klp_pkg::CALC_W'(kl_cur) - klp_pkg::CALC_W'(kb_cur) + klp_pkg::CALC_W'(1);
  assign val_off_w = klp_pkg::CALC_W'(vb_cur);
  assign val_len_w = klp_pkg::CALC_W'(pos_cur) - klp_pkg::CALC_W'(vb_cur);
  assign line_w    = klp_pkg::CALC_W'(line_cur);

  always_comb begin
    ph_nxt   = ph_cur;
    pos_nxt  = pos_cur;
    line_nxt = line_cur;
    kb_nxt   = kb_cur;
    kl_nxt   = kl_cur;
    vb_nxt   = vb_cur;
    emit     = 1'b0;
    advance  = 1'b0;
    rec_new             = '0;
    rec_new.kind        = klp_pkg::REC_ERROR;
    rec_new.line_number = line_w[klp_pkg::LINE_NUM_W-1:0];
    rec_new.error_code  = klp_pkg::ERR_NO_DELIM;
    if (ph_cur != PH_HALT) begin
      if (pos_cur >= klp_pkg::POS_W'(klp_pkg::MAX_TEXT_BYTES)) begin
        emit               = 1'b1;
        rec_new.error_code = klp_pkg::ERR_TOO_LARGE;
        ph_nxt             = PH_HALT;
      end else begin
        advance = 1'b1;
        unique case (ph_cur)
          PH_KEY_START: begin
            if (tok.is_key) begin
              kb_nxt = pos_off;
              ph_nxt = PH_KEY_CHAR;
            end
          end
          PH_KEY_CHAR: begin
            priority if (tok.is_newline) begin
              emit               = 1'b1;
              rec_new.error_code = klp_pkg::ERR_NO_DELIM;
            end else if (tok.is_space) begin
              kl_nxt = pos_off - klp_pkg::OFF_W'(1);
              ph_nxt = PH_DELIM;
            end else if (tok.is_equals) begin
              kl_nxt = pos_off - klp_pkg::OFF_W'(1);
              ph_nxt = PH_VAL_START;
            end else if (tok.is_key) begin
              ph_nxt = PH_KEY_CHAR;
            end else begin
              emit               = 1'b1;
              rec_new.error_code = klp_pkg::ERR_KEY_GARBAGE;
            end
          end
          PH_DELIM: begin
            priority if (tok.is_equals) begin
              ph_nxt = PH_VAL_START;
            end else if (tok.is_newline) begin
              emit               = 1'b1;
              rec_new.error_code = klp_pkg::ERR_NO_DELIM;
            end else begin
              emit               = 1'b1;
              rec_new.error_code = klp_pkg::ERR_EXPECT_EQ;
            end
          end
          PH_VAL_START: begin
            priority if (tok.is_newline) begin
              emit               = 1'b1;
              rec_new.error_code = klp_pkg::ERR_NO_VALUE;
            end else if (tok.is_space) begin
              ph_nxt = PH_VAL_START;
            end else begin
              vb_nxt = pos_off;
              ph_nxt = PH_VAL_CHAR;
            end
          end
          PH_VAL_CHAR: begin
            if (tok.is_newline) begin
              emit                 = 1'b1;
              advance              = 1'b1;
              rec_new.kind         = klp_pkg::REC_PAIR;
              rec_new.key_offset   = key_off_w[klp_pkg::OFFSET_W-1:0];
              rec_new.key_length   = key_len_w[klp_pkg::LENGTH_W-1:0];
              rec_new.value_offset = val_off_w[klp_pkg::OFFSET_W-1:0];
              rec_new.value_length = val_len_w[klp_pkg::LENGTH_W-1:0];
              ph_nxt               = PH_KEY_START;
            end
          end
          default: begin
            advance = 1'b0;
          end
        endcase
        // an error halts without moving position or line
        if (emit && (rec_new.kind == klp_pkg::REC_ERROR)) begin
          advance = 1'b0;
          ph_nxt  = PH_HALT;
        end
        if (advance) begin
          pos_nxt = pos_cur + klp_pkg::POS_W'(1);
          if (tok.is_newline) begin
            line_nxt = line_cur + klp_pkg::LINE_W'(1);
          end
        end
      end
    end
  end

  // result queue
  assign out_empty = (ocnt_r == 2'd0);
  assign rec       = oq_r[orp_r];
  assign step      = tok_valid && ((ocnt_r != 2'd2) || out_pop);
  assign tok_pop   = step;
  assign opush     = step && emit;
  assign opop      = out_pop && !out_empty;

  always_comb begin
    owp_nxt  = opush ? ~owp_r : owp_r;
    orp_nxt  = opop ? ~orp_r : orp_r;
    ocnt_nxt = ocnt_r + 2'(opush) - 2'(opop);
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      oq_r[owp_r] <= rec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_KEY_START;
      pos_r  <= '0;
      line_r <= klp_pkg::LINE_W'(1);
      kb_r   <= '0;
      kl_r   <= '0;
      vb_r   <= '0;
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (step) begin
        ph_r   <= ph_nxt;
        pos_r  <= pos_nxt;
        line_r <= line_nxt;
        kb_r   <= kb_nxt;
        kl_r   <= kl_nxt;
        vb_r   <= vb_nxt;
      end
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

endmodule

>>> sv/key_value_line_parser_unit.sv
// Streaming key=value settings parser. One text byte is taken per clock cycle,
// sustained, whenever in_full is low; the limit is the parser state update in
// the back end. A byte is classified and queued in the front end, the back end
// steps the line parser on it once the result queue has room, and any pair or
// error record it causes is written to the result queue and shows on the out_
// ports once the records ahead of it have been taken. Two-word queues on each
// side of the back end let input and output stall independently. After an
// error record the parser ignores bytes until one arrives with in_restart set,
// which clears it first. A final line without a newline gives no record.
module key_value_line_parser_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [klp_pkg::BYTE_W-1:0]       in_text_byte,
  input  logic                             in_restart,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic                             out_record_kind,
  output logic [klp_pkg::OFFSET_W-1:0]     out_key_offset,
  output logic [klp_pkg::LENGTH_W-1:0]     out_key_length,
  output logic [klp_pkg::OFFSET_W-1:0]     out_value_offset,
  output logic [klp_pkg::LENGTH_W-1:0]     out_value_length,
  output logic [klp_pkg::LINE_NUM_W-1:0]   out_line_number,
  output logic [klp_pkg::ERR_W-1:0]        out_error_code
);

  logic          tok_valid;
  logic          tok_pop;
  klp_pkg::tok_t tok;
  klp_pkg::rec_t rec;

  klp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .text_byte (in_text_byte),
    .restart   (in_restart),
    .full      (in_full),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop)
  );

  klp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .rec       (rec)
  );

  assign out_record_kind  = rec.kind;
  assign out_key_offset   = rec.key_offset;
  assign out_key_length   = rec.key_length;
  assign out_value_offset = rec.value_offset;
  assign out_value_length = rec.value_length;
  assign out_line_number  = rec.line_number;
  assign out_error_code   = rec.error_code;

endmodule

>>> sv/klp_checker.sv
// port-level checks of the parser and their binding to the top level
module klp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_full,
  input logic                             out_empty,
  input logic                             out_pop,
  input logic                             out_record_kind,
  input logic [klp_pkg::OFFSET_W-1:0]     out_key_offset,
  input logic [klp_pkg::LENGTH_W-1:0]     out_key_length,
  input logic [klp_pkg::OFFSET_W-1:0]     out_value_offset,
  input logic [klp_pkg::LENGTH_W-1:0]     out_value_length,
  input logic [klp_pkg::LINE_NUM_W-1:0]   out_line_number,
  input logic [klp_pkg::ERR_W-1:0]        out_error_code
);

  // a waiting word holds until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_record_kind) &&
      $stable(out_key_offset) && $stable(out_key_length) &&
      $stable(out_value_offset) && $stable(out_value_length) &&
      $stable(out_line_number) && $stable(out_error_code)))
    else $error("result word changed while waiting");

  // error words carry zero offsets and lengths and a known code
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_record_kind == klp_pkg::REC_ERROR)) |->
      ((out_key_offset == '0) && (out_key_length == '0) &&
       (out_value_offset == '0) && (out_value_length == '0) &&
       ((out_error_code == klp_pkg::ERR_NO_DELIM) ||
        (out_error_code == klp_pkg::ERR_KEY_GARBAGE) ||
        (out_error_code == klp_pkg::ERR_EXPECT_EQ) ||
        (out_error_code == klp_pkg::ERR_NO_VALUE) ||
        (out_error_code == klp_pkg::ERR_TOO_LARGE))))
    else $error("malformed error word");

  // pair words carry a clear error code
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_record_kind == klp_pkg::REC_PAIR)) |-> (out_error_code == '0))
    else $error("pair word with error code set");

  // reset empties both queues
  assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule

bind key_value_line_parser_unit klp_checker u_klp_checker (.*);
